/* rtl/windowed_vibration_variance_detector_macros.svh */
// assertion macros shared by the vibration detector rtl
`ifndef WINDOWED_VIBRATION_VARIANCE_DETECTOR_MACROS_SVH
`define WINDOWED_VIBRATION_VARIANCE_DETECTOR_MACROS_SVH

`ifndef SYNTHESIS

// condition must hold at every edge out of reset
`define WVVD_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define WVVD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define WVVD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define WVVD_ASSERT_ALWAYS(label, cond, msg)
`define WVVD_ASSERT_SAME(label, ante, cons, msg)
`define WVVD_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

/* rtl/wvvd_pkg.sv */
// shared types and constants of the windowed vibration variance detector
package wvvd_pkg;

  // fixed field widths
  localparam int RAW_W       = 16;
  localparam int SAMPLE_W    = 20;
  localparam int THR_W       = 20;
  localparam int MAG_W       = 20;
  localparam int AXIS_W      = 2;
  localparam int RANGE_W     = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 20;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 24;

  // dominant axis codes
  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  // register reset values
  localparam logic [RANGE_W-1:0] RANGE_RESET     = 2'd1;
  localparam logic [THR_W-1:0]   THRESHOLD_RESET = 20'd32768;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_X  = 3'd0,
    CFG_OFFSET_Y  = 3'd1,
    CFG_OFFSET_Z  = 3'd2,
    CFG_RANGE     = 3'd3,
    CFG_THRESHOLD = 3'd4
  } cfg_reg_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_MUL,
    S_TOTAL,
    S_ROOT,
    S_SCALE,
    S_FIX,
    S_ROUND,
    S_DONE
  } state_t;

  // multiplier schedule, one square per step
  typedef enum logic [3:0] {
    OP_OLD_X,
    OP_NEW_X,
    OP_OLD_Y,
    OP_NEW_Y,
    OP_OLD_Z,
    OP_NEW_Z,
    OP_VAR_X,
    OP_VAR_Y,
    OP_VAR_Z,
    OP_LIMIT,
    OP_DRAIN
  } op_t;

endpackage

/* rtl/windowed_vibration_variance_detector.sv */
// sliding window rms vibration detector with one shared multiplier
//
//  channel   direction  handshake                   payload
//  s_axis    in         s_axis_tvalid/tready        accel_x, accel_y, accel_z
//  m_axis    out        m_axis_tvalid/tready        magnitude, main_axis, imbalanced
//  cfg       in         cfg_valid/cfg_ready         cfg_index, cfg_data
//
// a new sample is taken only in S_IDLE, once the previous one has run through every state;
// ROOT_W is half the width of the summed variance
// and sets the length of the bit-per-cycle square root loop.
// rst is synchronous active high and clears the window (valid bits), sums and registers.
// the result waits in an output register; the sequencer only stalls at its last step
// while that register still holds an untaken result.
`include "windowed_vibration_variance_detector_macros.svh"

module windowed_vibration_variance_detector #(
  parameter int WINDOW = 50
) (
  input  logic                              clk,
  input  logic                              rst,
  // accel_x [15:0], accel_y [31:16], accel_z [47:32]
  input  logic [wvvd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // magnitude [19:0], main_axis [21:20], imbalanced [22], zero [23]
  output logic [wvvd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wvvd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wvvd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import wvvd_pkg::*;

  // derived widths
  localparam int WLOG   = $clog2(WINDOW);
  localparam int SLOT_W = (WLOG < 1) ? 1 : WLOG;
  localparam int WIN_W  = $clog2(WINDOW + 1);
  localparam int SMAG_W = SAMPLE_W - 1;
  localparam int SUM_W  = SAMPLE_W + WLOG;
  localparam int SSQ_W  = 2 * SMAG_W + WLOG;
  localparam int VAR_W  = 2 * SMAG_W + 2 * WLOG;
  localparam int TOT_W  = VAR_W + 2;
  localparam int ROOT_W = (TOT_W + 1) / 2;
  localparam int LIM_W  = THR_W + WIN_W;
  localparam int MUL_A  = (SUM_W - 1 > LIM_W) ? SUM_W - 1 : LIM_W;
  localparam int MUL_W  = (MUL_A > ROOT_W) ? MUL_A : ROOT_W;
  localparam int PROD_W = 2 * MUL_W;
  localparam int CMP_W  = (TOT_W > PROD_W) ? TOT_W : PROD_W;
  localparam int CNT_W  = $clog2(ROOT_W);
  localparam int ROW_W  = 3 * SAMPLE_W;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);
  localparam logic [WIN_W-1:0]  WIN_VAL   = WIN_W'(WINDOW);
  localparam logic [CNT_W-1:0]  LAST_STEP = CNT_W'(ROOT_W - 1);
  localparam logic [ROOT_W-1:0] RECIP     = ROOT_W'((64'd1 << ROOT_W) / WINDOW);
  localparam logic [ROOT_W-1:0] WIN_ROOT  = ROOT_W'(WINDOW);

  // magnitude of a signed sample
  function automatic logic [SMAG_W-1:0] abs_smp(input logic signed [SAMPLE_W-1:0] v);
    logic [SAMPLE_W-1:0] n;
    n = v[SAMPLE_W-1] ? (~v + 1'b1) : v;
    return n[SMAG_W-1:0];
  endfunction

  // magnitude of a signed window sum
  function automatic logic [SUM_W-2:0] abs_sum(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-1:0] n;
    n = v[SUM_W-1] ? (~v + 1'b1) : v;
    return n[SUM_W-2:0];
  endfunction

  // configuration registers
  logic signed [RAW_W-1:0] offset_x, offset_y, offset_z;
  logic [RANGE_W-1:0]      accel_range;
  logic [THR_W-1:0]        threshold;

  // sequencer
  state_t state, state_next;
  op_t    op, op_d;
  logic   acc_en;
  logic   out_load;

  // window memory and its bookkeeping
  logic [ROW_W-1:0]  ring [WINDOW];
  logic [ROW_W-1:0]  rd_row;
  logic [WINDOW-1:0] filled;
  logic [SLOT_W-1:0] slot;

  // running sums per axis
  logic signed [SUM_W-1:0] sum_x, sum_y, sum_z;
  logic [SSQ_W-1:0]        ssq_x, ssq_y, ssq_z;

  // per item datapath
  logic signed [SAMPLE_W-1:0] new_x, new_y, new_z;
  logic signed [SAMPLE_W-1:0] old_x, old_y, old_z;
  logic signed [SAMPLE_W-1:0] rd_x, rd_y, rd_z;
  logic [MUL_W-1:0]           mul_a, mul_b;
  logic [PROD_W-1:0]          prod;
  logic [VAR_W-1:0]           var_x, var_y, var_z;
  logic [PROD_W-1:0]          lim_sq;
  logic [TOT_W-1:0]           total, total_sum;
  logic [LIM_W-1:0]           limit;
  logic [AXIS_W-1:0]          dom;
  logic                       imb;

  // square root loop
  logic [2*ROOT_W-1:0] t_sh;
  logic [ROOT_W:0]     rem;
  logic [ROOT_W-1:0]   root;
  logic [CNT_W-1:0]    step;
  logic [ROOT_W+2:0]   rem_sh, trial, rem_sub;
  logic                take;

  // divide by window
  logic [ROOT_W-1:0] quot, quot_w, quot_rem;

  // output register
  logic [MAG_W-1:0]  out_mag;
  logic [AXIS_W-1:0] out_dom;
  logic              out_imb;

  // raw input fields
  logic signed [RAW_W-1:0] raw_x, raw_y, raw_z;
  assign raw_x = s_axis_tdata[RAW_W-1:0];
  assign raw_y = s_axis_tdata[2*RAW_W-1:RAW_W];
  assign raw_z = s_axis_tdata[3*RAW_W-1:2*RAW_W];

  // configuration write, always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x    <= '0;
      offset_y    <= '0;
      offset_z    <= '0;
      accel_range <= RANGE_RESET;
      threshold   <= THRESHOLD_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_OFFSET_X:  offset_x    <= cfg_data[RAW_W-1:0];
        CFG_OFFSET_Y:  offset_y    <= cfg_data[RAW_W-1:0];
        CFG_OFFSET_Z:  offset_z    <= cfg_data[RAW_W-1:0];
        CFG_RANGE:     accel_range <= cfg_data[RANGE_W-1:0];
        CFG_THRESHOLD: threshold   <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) state_next = S_LOAD;
      end
      S_LOAD:  state_next = S_MUL;
      S_MUL: begin
        if (op == OP_DRAIN) state_next = S_TOTAL;
      end
      S_TOTAL: state_next = S_ROOT;
      S_ROOT: begin
        if (step == LAST_STEP) state_next = S_SCALE;
      end
      S_SCALE: state_next = S_FIX;
      S_FIX:   state_next = S_ROUND;
      S_ROUND: state_next = S_DONE;
      S_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // multiplier schedule counter and accumulate stage tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      op     <= OP_OLD_X;
      op_d   <= OP_OLD_X;
      acc_en <= 1'b0;
    end else begin
      op_d   <= op;
      acc_en <= (state == S_MUL) && (op != OP_DRAIN);
      if ((state == S_MUL) && (op != OP_DRAIN)) begin
        op <= op_t'(op + 4'd1);
      end else begin
        op <= OP_OLD_X;
      end
    end
  end

  // offset removal and range shift on transfer
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      new_x <= (SAMPLE_W'(raw_x) - SAMPLE_W'(offset_x)) <<< accel_range;
      new_y <= (SAMPLE_W'(raw_y) - SAMPLE_W'(offset_y)) <<< accel_range;
      new_z <= (SAMPLE_W'(raw_z) - SAMPLE_W'(offset_z)) <<< accel_range;
    end
  end

  // window memory, registered read of the slot about to be replaced
  always_ff @(posedge clk) begin
    rd_row <= ring[slot];
    if (state == S_LOAD) begin
      ring[slot] <= {new_z, new_y, new_x};
    end
  end

  // unwritten slots read as zero samples
  assign rd_x = filled[slot] ? rd_row[SAMPLE_W-1:0] : '0;
  assign rd_y = filled[slot] ? rd_row[2*SAMPLE_W-1:SAMPLE_W] : '0;
  assign rd_z = filled[slot] ? rd_row[3*SAMPLE_W-1:2*SAMPLE_W] : '0;

  always_ff @(posedge clk) begin
    if (state == S_LOAD) begin
      old_x <= rd_x;
      old_y <= rd_y;
      old_z <= rd_z;
    end
  end

  // slot pointer, valid bits, window sums and sums of squares
  always_ff @(posedge clk) begin
    if (rst) begin
      slot   <= '0;
      filled <= '0;
      sum_x  <= '0;
      sum_y  <= '0;
      sum_z  <= '0;
      ssq_x  <= '0;
      ssq_y  <= '0;
      ssq_z  <= '0;
    end else begin
      if (state == S_LOAD) begin
        filled[slot] <= 1'b1;
        slot         <= (slot == LAST_SLOT) ? '0 : slot + 1'b1;
        sum_x        <= sum_x + SUM_W'(new_x) - SUM_W'(rd_x);
        sum_y        <= sum_y + SUM_W'(new_y) - SUM_W'(rd_y);
        sum_z        <= sum_z + SUM_W'(new_z) - SUM_W'(rd_z);
      end
      if (acc_en) begin
        unique case (op_d)
          OP_OLD_X: ssq_x <= ssq_x - prod[SSQ_W-1:0];
          OP_NEW_X: ssq_x <= ssq_x + prod[SSQ_W-1:0];
          OP_OLD_Y: ssq_y <= ssq_y - prod[SSQ_W-1:0];
          OP_NEW_Y: ssq_y <= ssq_y + prod[SSQ_W-1:0];
          OP_OLD_Z: ssq_z <= ssq_z - prod[SSQ_W-1:0];
          OP_NEW_Z: ssq_z <= ssq_z + prod[SSQ_W-1:0];
          OP_VAR_X, OP_VAR_Y, OP_VAR_Z, OP_LIMIT, OP_DRAIN: ;
        endcase
      end
    end
  end

  // threshold scaled by window length
  assign limit = LIM_W'(threshold) * LIM_W'(WIN_VAL);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == S_SCALE) begin
      mul_a = MUL_W'(root);
      mul_b = MUL_W'(RECIP);
    end else begin
      unique case (op)
        OP_OLD_X: mul_a = MUL_W'(abs_smp(old_x));
        OP_NEW_X: mul_a = MUL_W'(abs_smp(new_x));
        OP_OLD_Y: mul_a = MUL_W'(abs_smp(old_y));
        OP_NEW_Y: mul_a = MUL_W'(abs_smp(new_y));
        OP_OLD_Z: mul_a = MUL_W'(abs_smp(old_z));
        OP_NEW_Z: mul_a = MUL_W'(abs_smp(new_z));
        OP_VAR_X: mul_a = MUL_W'(abs_sum(sum_x));
        OP_VAR_Y: mul_a = MUL_W'(abs_sum(sum_y));
        OP_VAR_Z: mul_a = MUL_W'(abs_sum(sum_z));
        OP_LIMIT: mul_a = MUL_W'(limit);
        OP_DRAIN: mul_a = '0;
      endcase
      mul_b = mul_a;
    end
  end

  // shared multiplier, product registered
  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // scaled variances and squared limit
  always_ff @(posedge clk) begin
    if (acc_en) begin
      unique case (op_d)
        OP_VAR_X: var_x <= VAR_W'(ssq_x) * VAR_W'(WIN_VAL) - prod[VAR_W-1:0];
        OP_VAR_Y: var_y <= VAR_W'(ssq_y) * VAR_W'(WIN_VAL) - prod[VAR_W-1:0];
        OP_VAR_Z: var_z <= VAR_W'(ssq_z) * VAR_W'(WIN_VAL) - prod[VAR_W-1:0];
        OP_LIMIT: lim_sq <= prod;
        OP_OLD_X, OP_NEW_X, OP_OLD_Y, OP_NEW_Y, OP_OLD_Z, OP_NEW_Z, OP_DRAIN: ;
      endcase
    end
  end

  assign total_sum = TOT_W'(var_x) + TOT_W'(var_y) + TOT_W'(var_z);

  // one square root digit per cycle
  assign rem_sh  = {rem, t_sh[2*ROOT_W-1 -: 2]};
  assign trial   = {1'b0, root, 2'b01};
  assign take    = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;

  // product of the quotient estimate and the window length
  assign quot_w   = quot * WIN_ROOT;
  assign quot_rem = root - quot_w;

  // total, dominant axis, square root, imbalance compare, divide by window
  always_ff @(posedge clk) begin
    unique case (state)
      S_TOTAL: begin
        total <= total_sum;
        t_sh  <= (2*ROOT_W)'(total_sum);
        rem   <= '0;
        root  <= '0;
        step  <= '0;
        if (var_x > var_y && var_x > var_z) begin
          dom <= AXIS_X;
        end else if (var_y > var_z) begin
          dom <= AXIS_Y;
        end else begin
          dom <= AXIS_Z;
        end
      end
      S_ROOT: begin
        t_sh <= t_sh << 2;
        step <= step + 1'b1;
        if (take) begin
          rem  <= rem_sub[ROOT_W:0];
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= rem_sh[ROOT_W:0];
          root <= {root[ROOT_W-2:0], 1'b0};
        end
      end
      S_SCALE: begin
        imb <= CMP_W'(total) > CMP_W'(lim_sq);
      end
      S_FIX: begin
        quot <= prod[2*ROOT_W-1:ROOT_W];
      end
      S_ROUND: begin
        if (quot_rem >= WIN_ROOT) quot <= quot + 1'b1;
      end
      S_IDLE, S_LOAD, S_MUL, S_DONE: ;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_mag <= (|quot[ROOT_W-1:MAG_W]) ? '1 : quot[MAG_W-1:0];
      out_dom <= dom;
      out_imb <= imb;
    end
  end

  assign m_axis_tdata = {1'b0, out_imb, out_dom, out_mag};

  // checks
  `WVVD_ASSERT_NEXT(a_transfer_starts_load, s_axis_tvalid && s_axis_tready, state == S_LOAD, "transfer did not start a window update")
  `WVVD_ASSERT_ALWAYS(a_slot_in_window, slot <= LAST_SLOT, "write slot left the window")
  `WVVD_ASSERT_SAME(a_quotient_exact, state == S_DONE, root >= quot_w && quot_rem < WIN_ROOT, "root divided by window is off by one")

endmodule
